// File: rtl/core/cra_pkg.sv
// shared constants, types and helpers for the circle/rectangle overlap area pipeline
package cra_pkg;

  // coordinate format; the fraction width only sets how the bits are read
  localparam int COORD_BITS        = 32;
  localparam int ARCSIN_ITERATIONS = 24;

  localparam int RADIUS_BITS = COORD_BITS - 2;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS     = 2 * RADIUS_BITS;
  localparam int ARC_BITS    = SQ_BITS + 2;
  localparam int D_BITS      = SQ_BITS + 4;
  localparam int SUM_BITS    = SQ_BITS + 5;
  localparam int AREA_BITS   = 2 * COORD_BITS - 1;
  localparam int PROD_BITS   = 63;

  // cordic vector and angle formats
  localparam int VEC_SCALE    = 28;
  localparam int VEC_BITS     = RADIUS_BITS + 32;
  localparam int Z_BITS       = 33;
  localparam int ANG_BITS     = 31;
  localparam int CORDIC_STEPS = (ARCSIN_ITERATIONS > 32) ? 32 : ARCSIN_ITERATIONS;

  // four distinct offsets (x1, x2, y1, y2) and four corners
  localparam int TERMS   = 4;
  localparam int CORNERS = 4;
  localparam int CORNER_X [CORNERS] = '{1, 0, 1, 0};
  localparam int CORNER_Y [CORNERS] = '{2, 2, 3, 3};

  // arc unit: difference, root steps, rotation steps, clamp, multiply, rounded sum
  localparam int ARC_LAT    = RADIUS_BITS + CORDIC_STEPS + 4;
  localparam int PIPE_DEPTH = ARC_LAT + 7;

  localparam logic [ANG_BITS-1:0] PI_2_Q30  = 31'd1686629713;
  localparam logic [63:0]         ROUND_Q30 = 64'h0000_0000_2000_0000;

  localparam logic signed [SUM_BITS-1:0] AREA_MAX =
      (SUM_BITS'(1) << (AREA_BITS - 1)) - SUM_BITS'(1);
  localparam logic signed [SUM_BITS-1:0] AREA_MIN =
      SUM_BITS'(0) - (SUM_BITS'(1) << (AREA_BITS - 1));

  // trunc(atan(2^-i) * 2^30)
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
    32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic [RADIUS_BITS-1:0] u;
    logic [SQ_BITS-1:0]     r2;
  } sqrt_side_t;

  typedef struct packed {
    logic [RADIUS_BITS-1:0] u;
    logic [RADIUS_BITS-1:0] c;
    logic [SQ_BITS-1:0]     r2;
  } cordic_side_t;

  typedef struct packed {
    logic [CORNERS-1:0]              in_circle;
    logic [CORNERS-1:0]              neg;
    logic [CORNERS-1:0][SQ_BITS-1:0] prod;
    logic [ARC_BITS-1:0]             pterm;
  } corner_side_t;

  // combine the two partial products of a wide value times a q30 factor, rounded
  function automatic logic [ARC_BITS-1:0] q30_round(input logic [PROD_BITS-1:0] hi,
                                                    input logic [PROD_BITS-1:0] lo);
    logic [63:0] t;
    logic [63:0] s;
    t = {1'b0, lo} + ROUND_Q30;
    s = ({1'b0, hi} << 2) + (t >> 30);
    return s[ARC_BITS-1:0];
  endfunction

endpackage

// File: rtl/core/circle_rectangle_overlap_area_top.sv
// circle/rectangle overlap area, fully pipelined top level
//
//  channel  direction  handshake                  word
//  in       input      in_valid_i / in_stall_o    rectangle edges, centre, radius
//  out      output     out_valid_o / out_stall_i  overlap_area_o
//
// the pipe has one stage per root bit and one per cordic rotation,
// plus front end, multiplies and the corner sum.
// one word enters and one leaves every cycle while the output is not stalled.
// reset clears only the valid bits of the stages; data registers are not reset.
// a stall on a full output register freezes every stage, so nothing is lost or repeated.
module circle_rectangle_overlap_area_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [cra_pkg::COORD_BITS-1:0]  rect_left_i,
  input  logic signed [cra_pkg::COORD_BITS-1:0]  rect_top_i,
  input  logic signed [cra_pkg::COORD_BITS-1:0]  rect_right_i,
  input  logic signed [cra_pkg::COORD_BITS-1:0]  rect_bottom_i,
  input  logic signed [cra_pkg::COORD_BITS-1:0]  centre_x_i,
  input  logic signed [cra_pkg::COORD_BITS-1:0]  centre_y_i,
  input  logic [cra_pkg::RADIUS_BITS-1:0]        radius_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [cra_pkg::AREA_BITS-1:0]   overlap_area_o
);

  logic                                 en;
  logic [cra_pkg::PIPE_DEPTH-1:0]       vld_q;

  logic signed [cra_pkg::DIFF_BITS-1:0] d1_q  [cra_pkg::TERMS];
  logic [cra_pkg::RADIUS_BITS-1:0]      r1_q;
  logic [cra_pkg::RADIUS_BITS-1:0]      u2_q  [cra_pkg::TERMS];
  logic [cra_pkg::TERMS-1:0]            sgn2_q;
  logic [cra_pkg::SQ_BITS-1:0]          r2_2_q;
  logic [cra_pkg::RADIUS_BITS-1:0]      u3_q  [cra_pkg::TERMS];
  logic [cra_pkg::SQ_BITS-1:0]          usq3_q [cra_pkg::TERMS];
  logic [cra_pkg::SQ_BITS-1:0]          prod3_q [cra_pkg::CORNERS];
  logic [cra_pkg::CORNERS-1:0]          neg3_q;
  logic [cra_pkg::SQ_BITS-1:0]          r2_3_q;
  logic [cra_pkg::PROD_BITS-1:0]        pilo3_q;
  logic [cra_pkg::PROD_BITS-1:0]        pihi3_q;
  logic [63:0]                          r2_2_ext;
  cra_pkg::corner_side_t                side_d;
  cra_pkg::corner_side_t                dly_q [cra_pkg::ARC_LAT];
  logic [cra_pkg::ARC_BITS-1:0]         arc [cra_pkg::TERMS];
  logic signed [cra_pkg::D_BITS-1:0]    dsum_q [cra_pkg::CORNERS];
  cra_pkg::corner_side_t                f1side_q;
  logic signed [cra_pkg::D_BITS-1:0]    corner_q [cra_pkg::CORNERS];
  logic signed [cra_pkg::SUM_BITS-1:0]  sum_q;
  logic signed [cra_pkg::AREA_BITS-1:0] area_q;

  // the whole pipe moves unless a finished word is held at the output
  assign en         = !(vld_q[cra_pkg::PIPE_DEPTH-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[cra_pkg::PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // corner offsets in the circle frame, full width
  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0] <= cra_pkg::DIFF_BITS'(rect_left_i) - cra_pkg::DIFF_BITS'(centre_x_i);
      d1_q[1] <= cra_pkg::DIFF_BITS'(rect_right_i) - cra_pkg::DIFF_BITS'(centre_x_i);
      d1_q[2] <= cra_pkg::DIFF_BITS'(rect_top_i) - cra_pkg::DIFF_BITS'(centre_y_i);
      d1_q[3] <= cra_pkg::DIFF_BITS'(rect_bottom_i) - cra_pkg::DIFF_BITS'(centre_y_i);
      r1_q    <= radius_i;
    end
  end

  // fold sign and clamp magnitude to the radius
  always_ff @(posedge clk_i) begin
    logic [cra_pkg::DIFF_BITS-1:0] mag;
    if (en) begin
      for (int i = 0; i < cra_pkg::TERMS; i++) begin
        mag = d1_q[i][cra_pkg::DIFF_BITS-1] ? cra_pkg::DIFF_BITS'(-d1_q[i])
                                            : cra_pkg::DIFF_BITS'(d1_q[i]);
        if (mag > cra_pkg::DIFF_BITS'(r1_q)) begin
          u2_q[i] <= r1_q;
        end else begin
          u2_q[i] <= mag[cra_pkg::RADIUS_BITS-1:0];
        end
        sgn2_q[i] <= d1_q[i][cra_pkg::DIFF_BITS-1];
      end
      r2_2_q <= cra_pkg::SQ_BITS'(r1_q) * cra_pkg::SQ_BITS'(r1_q);
    end
  end

  // squares, corner products and the r^2*pi/2 partial products
  assign r2_2_ext = 64'(r2_2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < cra_pkg::TERMS; i++) begin
        u3_q[i]   <= u2_q[i];
        usq3_q[i] <= cra_pkg::SQ_BITS'(u2_q[i]) * cra_pkg::SQ_BITS'(u2_q[i]);
      end
      for (int k = 0; k < cra_pkg::CORNERS; k++) begin
        prod3_q[k] <= cra_pkg::SQ_BITS'(u2_q[cra_pkg::CORNER_X[k]])
                    * cra_pkg::SQ_BITS'(u2_q[cra_pkg::CORNER_Y[k]]);
        neg3_q[k]  <= sgn2_q[cra_pkg::CORNER_X[k]] ^ sgn2_q[cra_pkg::CORNER_Y[k]];
      end
      r2_3_q  <= r2_2_q;
      pilo3_q <= cra_pkg::PROD_BITS'(r2_2_ext[31:0]) * cra_pkg::PROD_BITS'(cra_pkg::PI_2_Q30);
      pihi3_q <= cra_pkg::PROD_BITS'(r2_2_ext[63:32])
               * cra_pkg::PROD_BITS'(cra_pkg::PI_2_Q30);
    end
  end

  // in-circle test and quarter-circle term
  always_comb begin
    for (int k = 0; k < cra_pkg::CORNERS; k++) begin
      side_d.in_circle[k] = !((cra_pkg::SQ_BITS+1)'(usq3_q[cra_pkg::CORNER_X[k]])
                            + (cra_pkg::SQ_BITS+1)'(usq3_q[cra_pkg::CORNER_Y[k]])
                            > (cra_pkg::SQ_BITS+1)'(r2_3_q));
      side_d.prod[k]      = prod3_q[k];
    end
    side_d.neg   = neg3_q;
    side_d.pterm = cra_pkg::q30_round(pihi3_q, pilo3_q);
  end

  // corner data waits alongside the arc units
  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= side_d;
      for (int j = 1; j < cra_pkg::ARC_LAT; j++) begin
        dly_q[j] <= dly_q[j-1];
      end
    end
  end

  // one arc unit per distinct offset
  for (genvar i = 0; i < cra_pkg::TERMS; i++) begin : g_arc
    cra_arc u_arc (
      .clk_i (clk_i),
      .en_i  (en),
      .u_i   (u3_q[i]),
      .usq_i (usq3_q[i]),
      .r2_i  (r2_3_q),
      .arc_o (arc[i])
    );
  end

  // arc sum minus the quarter-circle term
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < cra_pkg::CORNERS; k++) begin
        dsum_q[k] <= cra_pkg::D_BITS'(arc[cra_pkg::CORNER_X[k]])
                   + cra_pkg::D_BITS'(arc[cra_pkg::CORNER_Y[k]])
                   - cra_pkg::D_BITS'(dly_q[cra_pkg::ARC_LAT-1].pterm);
      end
      f1side_q <= dly_q[cra_pkg::ARC_LAT-1];
    end
  end

  // pick product or halved arc form, then apply the folded sign
  always_ff @(posedge clk_i) begin
    logic signed [cra_pkg::D_BITS-1:0] a;
    if (en) begin
      for (int k = 0; k < cra_pkg::CORNERS; k++) begin
        if (f1side_q.in_circle[k]) begin
          a = $signed(cra_pkg::D_BITS'(f1side_q.prod[k]));
        end else begin
          a = dsum_q[k] >>> 1;
        end
        corner_q[k] <= f1side_q.neg[k] ? -a : a;
      end
    end
  end

  // alternating corner sum
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= cra_pkg::SUM_BITS'(corner_q[0]) - cra_pkg::SUM_BITS'(corner_q[1])
             - cra_pkg::SUM_BITS'(corner_q[2]) + cra_pkg::SUM_BITS'(corner_q[3]);
    end
  end

  // saturate into the output word
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sum_q > cra_pkg::AREA_MAX) begin
        area_q <= cra_pkg::AREA_MAX[cra_pkg::AREA_BITS-1:0];
      end else if (sum_q < cra_pkg::AREA_MIN) begin
        area_q <= cra_pkg::AREA_MIN[cra_pkg::AREA_BITS-1:0];
      end else begin
        area_q <= sum_q[cra_pkg::AREA_BITS-1:0];
      end
    end
  end

  assign out_valid_o    = vld_q[cra_pkg::PIPE_DEPTH-1];
  assign overlap_area_o = area_q;

endmodule

// File: rtl/core/cra_isqrt.sv
// pipelined floor square root, one root bit per stage
module cra_isqrt (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [cra_pkg::SQ_BITS-1:0]      v_i,
  input  cra_pkg::sqrt_side_t              side_i,
  output logic [cra_pkg::RADIUS_BITS-1:0]  root_o,
  output cra_pkg::sqrt_side_t              side_o
);

  logic [cra_pkg::RADIUS_BITS:0]   rem_q  [cra_pkg::RADIUS_BITS];
  logic [cra_pkg::RADIUS_BITS:0]   rem_d  [cra_pkg::RADIUS_BITS];
  logic [cra_pkg::RADIUS_BITS-1:0] root_q [cra_pkg::RADIUS_BITS];
  logic [cra_pkg::RADIUS_BITS-1:0] root_d [cra_pkg::RADIUS_BITS];
  logic [cra_pkg::SQ_BITS-1:0]     v_q    [cra_pkg::RADIUS_BITS];
  cra_pkg::sqrt_side_t             side_q [cra_pkg::RADIUS_BITS];

  // restoring digit recurrence on each stage
  always_comb begin
    logic [cra_pkg::RADIUS_BITS:0]   rem_in;
    logic [cra_pkg::RADIUS_BITS-1:0] root_in;
    logic [cra_pkg::SQ_BITS-1:0]     v_in;
    logic [cra_pkg::RADIUS_BITS+2:0] rem_sh;
    logic [cra_pkg::RADIUS_BITS+2:0] trial;
    logic [cra_pkg::RADIUS_BITS+2:0] diff;
    for (int k = 0; k < cra_pkg::RADIUS_BITS; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        v_in    = v_i;
      end else begin
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
        v_in    = v_q[k-1];
      end
      rem_sh = {rem_in, v_in[cra_pkg::SQ_BITS-1-2*k -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      diff   = rem_sh - trial;
      if (rem_sh >= trial) begin
        rem_d[k]  = diff[cra_pkg::RADIUS_BITS:0];
        root_d[k] = {root_in[cra_pkg::RADIUS_BITS-2:0], 1'b1};
      end else begin
        rem_d[k]  = rem_sh[cra_pkg::RADIUS_BITS:0];
        root_d[k] = {root_in[cra_pkg::RADIUS_BITS-2:0], 1'b0};
      end
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < cra_pkg::RADIUS_BITS; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
      v_q[0]    <= v_i;
      side_q[0] <= side_i;
      for (int k = 1; k < cra_pkg::RADIUS_BITS; k++) begin
        v_q[k]    <= v_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign root_o = root_q[cra_pkg::RADIUS_BITS-1];
  assign side_o = side_q[cra_pkg::RADIUS_BITS-1];

endmodule

// File: rtl/core/cra_cordic.sv
// pipelined cordic vectoring, one rotation per stage, angle in q30 radians
module cra_cordic (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [cra_pkg::VEC_BITS-1:0]  vx_i,
  input  logic signed [cra_pkg::VEC_BITS-1:0]  vy_i,
  input  cra_pkg::cordic_side_t                side_i,
  output logic signed [cra_pkg::Z_BITS-1:0]    z_o,
  output cra_pkg::cordic_side_t                side_o
);

  logic signed [cra_pkg::VEC_BITS-1:0] vx_q [cra_pkg::CORDIC_STEPS];
  logic signed [cra_pkg::VEC_BITS-1:0] vy_q [cra_pkg::CORDIC_STEPS];
  logic signed [cra_pkg::Z_BITS-1:0]   z_q  [cra_pkg::CORDIC_STEPS];
  logic signed [cra_pkg::VEC_BITS-1:0] vx_d [cra_pkg::CORDIC_STEPS];
  logic signed [cra_pkg::VEC_BITS-1:0] vy_d [cra_pkg::CORDIC_STEPS];
  logic signed [cra_pkg::Z_BITS-1:0]   z_d  [cra_pkg::CORDIC_STEPS];
  cra_pkg::cordic_side_t               side_q [cra_pkg::CORDIC_STEPS];

  // rotate toward the x axis, direction set by the sign of y
  always_comb begin
    logic signed [cra_pkg::VEC_BITS-1:0] vx_in;
    logic signed [cra_pkg::VEC_BITS-1:0] vy_in;
    logic signed [cra_pkg::Z_BITS-1:0]   z_in;
    logic signed [cra_pkg::VEC_BITS-1:0] dx;
    logic signed [cra_pkg::VEC_BITS-1:0] dy;
    logic signed [cra_pkg::Z_BITS-1:0]   at;
    for (int i = 0; i < cra_pkg::CORDIC_STEPS; i++) begin
      if (i == 0) begin
        vx_in = vx_i;
        vy_in = vy_i;
        z_in  = '0;
      end else begin
        vx_in = vx_q[i-1];
        vy_in = vy_q[i-1];
        z_in  = z_q[i-1];
      end
      dx = vy_in >>> i;
      dy = vx_in >>> i;
      at = {{(cra_pkg::Z_BITS-32){1'b0}}, cra_pkg::ATAN_Q30[i]};
      if (!vy_in[cra_pkg::VEC_BITS-1]) begin
        vx_d[i] = vx_in + dx;
        vy_d[i] = vy_in - dy;
        z_d[i]  = z_in + at;
      end else begin
        vx_d[i] = vx_in - dx;
        vy_d[i] = vy_in + dy;
        z_d[i]  = z_in - at;
      end
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < cra_pkg::CORDIC_STEPS; i++) begin
        vx_q[i] <= vx_d[i];
        vy_q[i] <= vy_d[i];
        z_q[i]  <= z_d[i];
      end
      side_q[0] <= side_i;
      for (int i = 1; i < cra_pkg::CORDIC_STEPS; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign z_o    = z_q[cra_pkg::CORDIC_STEPS-1];
  assign side_o = side_q[cra_pkg::CORDIC_STEPS-1];

endmodule

// File: rtl/core/cra_arc.sv
// arc term r^2*asin(u/r) + u*sqrt(r^2-u^2) for one clamped offset
module cra_arc (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [cra_pkg::RADIUS_BITS-1:0]  u_i,
  input  logic [cra_pkg::SQ_BITS-1:0]      usq_i,
  input  logic [cra_pkg::SQ_BITS-1:0]      r2_i,
  output logic [cra_pkg::ARC_BITS-1:0]     arc_o
);

  logic [cra_pkg::SQ_BITS-1:0]         v_q;
  cra_pkg::sqrt_side_t                 vside_q;
  logic [cra_pkg::RADIUS_BITS-1:0]     root;
  cra_pkg::sqrt_side_t                 sside;
  logic signed [cra_pkg::VEC_BITS-1:0] vx;
  logic signed [cra_pkg::VEC_BITS-1:0] vy;
  cra_pkg::cordic_side_t               cside;
  logic signed [cra_pkg::Z_BITS-1:0]   z;
  cra_pkg::cordic_side_t               zside;
  logic [cra_pkg::ANG_BITS-1:0]        ang_d;
  logic [cra_pkg::ANG_BITS-1:0]        ang_q;
  cra_pkg::cordic_side_t               aside_q;
  logic [63:0]                         r2_ext;
  logic [cra_pkg::PROD_BITS-1:0]       lo_q;
  logic [cra_pkg::PROD_BITS-1:0]       hi_q;
  logic [cra_pkg::SQ_BITS-1:0]         uc_q;
  logic [cra_pkg::ARC_BITS-1:0]        arc_q;

  // radicand r^2 - u^2
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q     <= r2_i - usq_i;
      vside_q <= '{u: u_i, r2: r2_i};
    end
  end

  cra_isqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .v_i    (v_q),
    .side_i (vside_q),
    .root_o (root),
    .side_o (sside)
  );

  // vector (c, u) scaled up for the rotation
  assign vx    = $signed(cra_pkg::VEC_BITS'(root) << cra_pkg::VEC_SCALE);
  assign vy    = $signed(cra_pkg::VEC_BITS'(sside.u) << cra_pkg::VEC_SCALE);
  assign cside = '{u: sside.u, c: root, r2: sside.r2};

  cra_cordic u_cordic (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .vx_i   (vx),
    .vy_i   (vy),
    .side_i (cside),
    .z_o    (z),
    .side_o (zside)
  );

  // clamp angle to [0, pi/2]
  always_comb begin
    if (z[cra_pkg::Z_BITS-1]) begin
      ang_d = '0;
    end else if (z > $signed({2'b00, cra_pkg::PI_2_Q30})) begin
      ang_d = cra_pkg::PI_2_Q30;
    end else begin
      ang_d = z[cra_pkg::ANG_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q   <= ang_d;
      aside_q <= zside;
    end
  end

  // r^2 * angle as two partial products, and u * c
  assign r2_ext = 64'(aside_q.r2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= cra_pkg::PROD_BITS'(r2_ext[31:0]) * cra_pkg::PROD_BITS'(ang_q);
      hi_q <= cra_pkg::PROD_BITS'(r2_ext[63:32]) * cra_pkg::PROD_BITS'(ang_q);
      uc_q <= cra_pkg::SQ_BITS'(aside_q.u) * cra_pkg::SQ_BITS'(aside_q.c);
    end
  end

  // rounded sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      arc_q <= cra_pkg::q30_round(hi_q, lo_q) + cra_pkg::ARC_BITS'(uc_q);
    end
  end

  assign arc_o = arc_q;

endmodule
